// ===== rtl/ffpa_pkg.sv =====
package ffpa_pkg;

	localparam int POOL_CAPACITY_DEF   = 4096;
	localparam int HEADER_BYTES_DEF    = 16;
	localparam int MIN_SPLIT_BYTES_DEF = 32;
	localparam int MAX_BLOCKS_DEF      = 64;

	localparam int POOL_MIN   = 64;
	localparam int RESET_POOL = 4096;

	localparam int SIZE_W = 12;
	localparam int ADDR_W = 12;
	localparam int CFG_W  = 13;

	typedef enum logic {
		ACT_ALLOC,
		ACT_FREE
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NO_FIT,
		STAT_OUT_OF_POOL,
		STAT_NOT_BLOCK
	} status_t;

	typedef struct packed {
		action_t             action;
		logic [SIZE_W-1:0]   req_size;
		logic [ADDR_W-1:0]   free_addr;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   data_addr;
		status_t             status;
	} out_item_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SET_LEN,
		CELL_LOAD_NEW,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_CLEAR
	} cell_op_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_CMP,
		S_PICK,
		S_GATHER,
		S_APPLY,
		S_SHIFT
	} state_t;

	typedef struct packed {
		logic cap_vec;
		logic use_hit;
		logic cap_sel;
		logic cap_nbr;
	} pick_ctl_t;

endpackage

// ===== rtl/first_fit_pool_allocator.sv =====
// First-fit pool allocator. The pool is kept as an address-ordered row of block
// cells (header offset, data length, used flag); inserting or removing a block
// shifts the cells behind it by one place per cycle. An item is accepted in
// idle and passes through compare in every cell, lowest-match pick, neighbor
// gather and update, where its result is loaded into the output register; no
// new item is taken until the allocator is back in idle. A free that merges
// with both neighbors adds a second shift step, and a result that is not taken
// holds the update until the output register frees up. After reset, and after
// every cfg_data write, an init step rebuilds the table as a single free block
// before items are accepted. Status 0 ok, 1 no fitting block, 2 address
// outside pool, 3 not a block's data start; data_addr is zero unless an
// allocate succeeds.
module first_fit_pool_allocator #(
	parameter int POOL_CAPACITY   = ffpa_pkg::POOL_CAPACITY_DEF,
	parameter int HEADER_BYTES    = ffpa_pkg::HEADER_BYTES_DEF,
	parameter int MIN_SPLIT_BYTES = ffpa_pkg::MIN_SPLIT_BYTES_DEF,
	parameter int MAX_BLOCKS      = ffpa_pkg::MAX_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ffpa_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ffpa_pkg::out_item_t          out_item,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [ffpa_pkg::CFG_W-1:0]   cfg_data
);
	import ffpa_pkg::*;

	localparam int N    = MAX_BLOCKS;
	localparam int AW   = $clog2(POOL_CAPACITY + 1);
	localparam int XW   = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
	localparam int XC   = (AW > CFG_W) ? AW : CFG_W;
	localparam int CNTW = $clog2(MAX_BLOCKS + 1);
	localparam int RESET_POOL_V = (RESET_POOL > POOL_CAPACITY) ? POOL_CAPACITY : RESET_POOL;

	typedef enum logic [2:0] {
		PLAN_NONE,
		PLAN_MARK,
		PLAN_SPLIT,
		PLAN_MERGE_L,
		PLAN_MERGE_R,
		PLAN_MERGE_LR
	} plan_t;

	state_t            state_q;
	state_t            state_d;
	logic [AW-1:0]     pool_q;
	logic [CNTW-1:0]   count_q;
	action_t           action_q;
	logic [SIZE_W-1:0] size_q;
	logic [AW-1:0]     hdr_q;
	logic              range_err_q;
	logic              out_valid_q;
	out_item_t         out_item_q;

	logic              in_acc;
	logic              cfg_acc;
	logic              slot_free;
	logic              commit;
	pick_ctl_t         pick_ctl;

	logic [XC-1:0]     cfg_ext;
	logic [AW-1:0]     pool_next;
	logic [XW-1:0]     addr_x;
	logic [XW-1:0]     hdr_x;
	logic              range_err;
	logic [AW-1:0]     len0;

	logic [AW-1:0]     c_start [N];
	logic [AW-1:0]     c_len [N];
	logic [N-1:0]      c_used;
	logic [N-1:0]      c_valid;
	logic [N-1:0]      c_fit;
	logic [N-1:0]      c_hit;
	cell_op_t          c_op [N];

	logic [AW-1:0]     p_start [N+2];
	logic [AW-1:0]     p_len [N+2];
	logic [N+1:0]      p_used;
	logic [N+1:0]      p_valid;

	logic [N-1:0]      sel_s2;
	logic [N-1:0]      above_s2;
	logic              found_s2;
	logic [AW-1:0]     sel_start_s3;
	logic [AW-1:0]     sel_len_s3;
	logic [AW-1:0]     lft_len_s3;
	logic              lft_used_s3;
	logic              lft_valid_s3;
	logic [AW-1:0]     rgt_len_s3;
	logic              rgt_used_s3;
	logic              rgt_valid_s3;
	logic [N-1:0]      lft_sel;
	logic [N-1:0]      nxt_sel;

	plan_t             plan;
	out_item_t         result;
	logic [AW-1:0]     size_a;
	logic [AW-1:0]     rem;
	logic              split;
	logic              lft_free;
	logic              rgt_free;
	logic [AW-1:0]     hdr_a;
	logic [AW-1:0]     set_len;
	logic              set_used;
	logic [AW-1:0]     new_start;
	logic [AW-1:0]     new_len;

	assign in_acc    = in_valid & in_ready;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign slot_free = ~out_valid_q | out_ready;
	assign commit    = (state_q == S_APPLY) & slot_free;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign hdr_a     = AW'(HEADER_BYTES);

	assign cfg_ext   = XC'(cfg_data);
	assign pool_next = (cfg_ext < XC'(POOL_MIN)) ? AW'(POOL_MIN) :
	                   (cfg_ext > XC'(POOL_CAPACITY)) ? AW'(POOL_CAPACITY) : AW'(cfg_ext);
	assign addr_x    = XW'(in_item.free_addr);
	assign hdr_x     = addr_x - XW'(HEADER_BYTES);
	assign range_err = (addr_x < XW'(HEADER_BYTES)) | (hdr_x >= XW'(pool_q));
	assign len0      = (pool_q > hdr_a) ? pool_q - hdr_a : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pool_q      <= AW'(RESET_POOL_V);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				pool_q <= pool_next;
			end
			if (state_q == S_INIT) begin
				count_q <= CNTW'(1);
			end else if (state_q == S_SHIFT) begin
				count_q <= count_q - CNTW'(1);
			end else if (commit) begin
				case (plan) inside
					PLAN_SPLIT:                            count_q <= count_q + CNTW'(1);
					PLAN_MERGE_L, PLAN_MERGE_R, PLAN_MERGE_LR: count_q <= count_q - CNTW'(1);
					default:                               count_q <= count_q;
				endcase
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q    <= in_item.action;
			size_q      <= in_item.req_size;
			hdr_q       <= AW'(hdr_x);
			range_err_q <= range_err;
		end
		if (commit) begin
			out_item_q <= result;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:   state_d = S_IDLE;
			S_IDLE: begin
				if (cfg_acc) begin
					state_d = S_INIT;
				end else if (in_acc) begin
					state_d = S_CMP;
				end
			end
			S_CMP:    state_d = S_PICK;
			S_PICK:   state_d = S_GATHER;
			S_GATHER: state_d = S_APPLY;
			S_APPLY: begin
				if (slot_free) begin
					state_d = (plan == PLAN_MERGE_LR) ? S_SHIFT : S_IDLE;
				end
			end
			S_SHIFT:  state_d = S_IDLE;
			default:  state_d = S_INIT;
		endcase
	end

	always_comb begin
		cfg_ready        = (state_q == S_IDLE);
		in_ready         = (state_q == S_IDLE) & ~cfg_valid;
		pick_ctl.cap_vec = (state_q == S_CMP);
		pick_ctl.use_hit = (action_q == ACT_FREE);
		pick_ctl.cap_sel = (state_q == S_PICK);
		pick_ctl.cap_nbr = (state_q == S_GATHER);
	end

	assign size_a   = AW'(size_q);
	assign rem      = sel_len_s3 - size_a;
	assign split    = (XW'(rem) > XW'(MIN_SPLIT_BYTES)) & (XW'(rem) > XW'(HEADER_BYTES)) &
	                  (count_q < CNTW'(MAX_BLOCKS));
	assign lft_free = lft_valid_s3 & ~lft_used_s3;
	assign rgt_free = rgt_valid_s3 & ~rgt_used_s3;

	always_comb begin
		plan             = PLAN_NONE;
		result.data_addr = '0;
		result.status    = STAT_OK;
		if (action_q == ACT_ALLOC) begin
			if (!found_s2) begin
				result.status = STAT_NO_FIT;
			end else begin
				plan             = split ? PLAN_SPLIT : PLAN_MARK;
				result.data_addr = ADDR_W'(sel_start_s3 + hdr_a);
			end
		end else if (range_err_q) begin
			result.status = STAT_OUT_OF_POOL;
		end else if (!found_s2) begin
			result.status = STAT_NOT_BLOCK;
		end else if (lft_free && rgt_free) begin
			plan = PLAN_MERGE_LR;
		end else if (lft_free) begin
			plan = PLAN_MERGE_L;
		end else if (rgt_free) begin
			plan = PLAN_MERGE_R;
		end else begin
			plan = PLAN_MARK;
		end
	end

	always_comb begin
		set_len   = sel_len_s3;
		set_used  = (action_q == ACT_ALLOC);
		new_start = sel_start_s3 + hdr_a + size_a;
		new_len   = rem - hdr_a;
		case (plan)
			PLAN_SPLIT: begin
				set_len  = size_a;
				set_used = 1'b1;
			end
			PLAN_MERGE_L: begin
				set_len  = lft_len_s3 + hdr_a + sel_len_s3;
				set_used = 1'b0;
			end
			PLAN_MERGE_R: begin
				set_len  = sel_len_s3 + hdr_a + rgt_len_s3;
				set_used = 1'b0;
			end
			PLAN_MERGE_LR: begin
				set_len  = lft_len_s3 + hdr_a + hdr_a + sel_len_s3 + rgt_len_s3;
				set_used = 1'b0;
			end
			default: begin
			end
		endcase
		if (state_q == S_INIT) begin
			new_start = '0;
			new_len   = len0;
		end
	end

	assign lft_sel = sel_s2 >> 1;
	assign nxt_sel = sel_s2 << 1;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			c_op[k] = CELL_HOLD;
			unique case (state_q)
				S_INIT: begin
					c_op[k] = (k == 0) ? CELL_LOAD_NEW : CELL_CLEAR;
				end
				S_APPLY: begin
					if (slot_free) begin
						case (plan) inside
							PLAN_MARK: begin
								if (sel_s2[k]) c_op[k] = CELL_SET_LEN;
							end
							PLAN_SPLIT: begin
								if (sel_s2[k]) c_op[k] = CELL_SET_LEN;
								else if (nxt_sel[k]) c_op[k] = CELL_LOAD_NEW;
								else if (above_s2[k]) c_op[k] = CELL_FROM_LEFT;
							end
							PLAN_MERGE_L, PLAN_MERGE_LR: begin
								if (lft_sel[k]) c_op[k] = CELL_SET_LEN;
								else if (sel_s2[k] || above_s2[k]) c_op[k] = CELL_FROM_RIGHT;
							end
							PLAN_MERGE_R: begin
								if (sel_s2[k]) c_op[k] = CELL_SET_LEN;
								else if (above_s2[k]) c_op[k] = CELL_FROM_RIGHT;
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (sel_s2[k] || above_s2[k]) c_op[k] = CELL_FROM_RIGHT;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		p_start[0]   = '0;
		p_len[0]     = '0;
		p_used[0]    = 1'b0;
		p_valid[0]   = 1'b0;
		p_start[N+1] = '0;
		p_len[N+1]   = '0;
		p_used[N+1]  = 1'b0;
		p_valid[N+1] = 1'b0;
		for (int k = 0; k < N; k++) begin
			p_start[k+1] = c_start[k];
			p_len[k+1]   = c_len[k];
			p_used[k+1]  = c_used[k];
			p_valid[k+1] = c_valid[k];
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		ffpa_cell #(
			.AW(AW),
			.XW(XW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (c_op[k]),
			.set_len  (set_len),
			.set_used (set_used),
			.new_start(new_start),
			.new_len  (new_len),
			.new_used (1'b0),
			.lft_start(p_start[k]),
			.lft_len  (p_len[k]),
			.lft_used (p_used[k]),
			.lft_valid(p_valid[k]),
			.rgt_start(p_start[k+2]),
			.rgt_len  (p_len[k+2]),
			.rgt_used (p_used[k+2]),
			.rgt_valid(p_valid[k+2]),
			.size     (size_q),
			.hdr      (hdr_q),
			.start    (c_start[k]),
			.len      (c_len[k]),
			.used     (c_used[k]),
			.valid    (c_valid[k]),
			.fit      (c_fit[k]),
			.hit      (c_hit[k])
		);
	end

	ffpa_pick #(
		.N (N),
		.AW(AW)
	) u_pick (
		.clk         (clk),
		.ctl         (pick_ctl),
		.fit         (c_fit),
		.hit         (c_hit),
		.start       (c_start),
		.len         (c_len),
		.used        (c_used),
		.valid       (c_valid),
		.sel_s2      (sel_s2),
		.above_s2    (above_s2),
		.found_s2    (found_s2),
		.sel_start_s3(sel_start_s3),
		.sel_len_s3  (sel_len_s3),
		.lft_len_s3  (lft_len_s3),
		.lft_used_s3 (lft_used_s3),
		.lft_valid_s3(lft_valid_s3),
		.rgt_len_s3  (rgt_len_s3),
		.rgt_used_s3 (rgt_used_s3),
		.rgt_valid_s3(rgt_valid_s3)
	);

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(c_valid) == int'(count_q))
		else $error("block count out of step with valid cells");

	a_valid_is_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((c_valid + N'(1)) & c_valid) == '0)
		else $error("valid cells not packed at the low end");

	a_no_adjacent_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |->
		(((c_valid & ~c_used) & ((c_valid & ~c_used) >> 1)) == '0))
		else $error("two adjacent free blocks left unmerged");

	a_single_select: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY || state_q == S_SHIFT) |-> $onehot0(sel_s2))
		else $error("more than one cell selected");

	a_result_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q && !out_ready)) |-> $past(state_q == S_APPLY))
		else $error("result beat loaded outside the update step");

endmodule

// ===== rtl/ffpa_cell.sv =====
module ffpa_cell #(
	parameter int AW = 13,
	parameter int XW = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffpa_pkg::cell_op_t            op,
	input  logic [AW-1:0]                 set_len,
	input  logic                          set_used,
	input  logic [AW-1:0]                 new_start,
	input  logic [AW-1:0]                 new_len,
	input  logic                          new_used,
	input  logic [AW-1:0]                 lft_start,
	input  logic [AW-1:0]                 lft_len,
	input  logic                          lft_used,
	input  logic                          lft_valid,
	input  logic [AW-1:0]                 rgt_start,
	input  logic [AW-1:0]                 rgt_len,
	input  logic                          rgt_used,
	input  logic                          rgt_valid,
	input  logic [ffpa_pkg::SIZE_W-1:0]   size,
	input  logic [AW-1:0]                 hdr,
	output logic [AW-1:0]                 start,
	output logic [AW-1:0]                 len,
	output logic                          used,
	output logic                          valid,
	output logic                          fit,
	output logic                          hit
);
	import ffpa_pkg::*;

	logic [AW-1:0] start_q;
	logic [AW-1:0] len_q;
	logic          used_q;
	logic          valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				CELL_LOAD_NEW:   valid_q <= 1'b1;
				CELL_FROM_LEFT:  valid_q <= lft_valid;
				CELL_FROM_RIGHT: valid_q <= rgt_valid;
				CELL_CLEAR:      valid_q <= 1'b0;
				default:         valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_SET_LEN: begin
				len_q  <= set_len;
				used_q <= set_used;
			end
			CELL_LOAD_NEW: begin
				start_q <= new_start;
				len_q   <= new_len;
				used_q  <= new_used;
			end
			CELL_FROM_LEFT: begin
				start_q <= lft_start;
				len_q   <= lft_len;
				used_q  <= lft_used;
			end
			CELL_FROM_RIGHT: begin
				start_q <= rgt_start;
				len_q   <= rgt_len;
				used_q  <= rgt_used;
			end
			default: begin
			end
		endcase
	end

	assign start = start_q;
	assign len   = len_q;
	assign used  = used_q;
	assign valid = valid_q;
	assign fit   = valid_q & ~used_q & (XW'(len_q) >= XW'(size));
	assign hit   = valid_q & (start_q == hdr);

endmodule

// ===== rtl/ffpa_pick.sv =====
module ffpa_pick #(
	parameter int N  = 64,
	parameter int AW = 13
) (
	input  logic                  clk,
	input  ffpa_pkg::pick_ctl_t   ctl,
	input  logic [N-1:0]          fit,
	input  logic [N-1:0]          hit,
	input  logic [AW-1:0]         start [N],
	input  logic [AW-1:0]         len [N],
	input  logic [N-1:0]          used,
	input  logic [N-1:0]          valid,
	output logic [N-1:0]          sel_s2,
	output logic [N-1:0]          above_s2,
	output logic                  found_s2,
	output logic [AW-1:0]         sel_start_s3,
	output logic [AW-1:0]         sel_len_s3,
	output logic [AW-1:0]         lft_len_s3,
	output logic                  lft_used_s3,
	output logic                  lft_valid_s3,
	output logic [AW-1:0]         rgt_len_s3,
	output logic                  rgt_used_s3,
	output logic                  rgt_valid_s3
);
	import ffpa_pkg::*;

	logic [N-1:0]  vec_s1;
	logic [N-1:0]  vec_dec;
	logic [N-1:0]  lft_mask;
	logic [N-1:0]  rgt_mask;
	logic [AW-1:0] g_sel_start;
	logic [AW-1:0] g_sel_len;
	logic [AW-1:0] g_lft_len;
	logic          g_lft_used;
	logic          g_lft_valid;
	logic [AW-1:0] g_rgt_len;
	logic          g_rgt_used;
	logic          g_rgt_valid;

	assign vec_dec  = vec_s1 - N'(1);
	assign lft_mask = sel_s2 >> 1;
	assign rgt_mask = sel_s2 << 1;

	always_ff @(posedge clk) begin
		if (ctl.cap_vec) begin
			vec_s1 <= ctl.use_hit ? hit : fit;
		end
		if (ctl.cap_sel) begin
			sel_s2   <= vec_s1 & ~vec_dec;
			above_s2 <= ~(vec_s1 ^ vec_dec);
			found_s2 <= |vec_s1;
		end
		if (ctl.cap_nbr) begin
			sel_start_s3 <= g_sel_start;
			sel_len_s3   <= g_sel_len;
			lft_len_s3   <= g_lft_len;
			lft_used_s3  <= g_lft_used;
			lft_valid_s3 <= g_lft_valid;
			rgt_len_s3   <= g_rgt_len;
			rgt_used_s3  <= g_rgt_used;
			rgt_valid_s3 <= g_rgt_valid;
		end
	end

	always_comb begin
		g_sel_start = '0;
		g_sel_len   = '0;
		g_lft_len   = '0;
		g_lft_used  = 1'b0;
		g_lft_valid = 1'b0;
		g_rgt_len   = '0;
		g_rgt_used  = 1'b0;
		g_rgt_valid = 1'b0;
		for (int k = 0; k < N; k++) begin
			g_sel_start = g_sel_start | (start[k] & {AW{sel_s2[k]}});
			g_sel_len   = g_sel_len | (len[k] & {AW{sel_s2[k]}});
			g_lft_len   = g_lft_len | (len[k] & {AW{lft_mask[k]}});
			g_lft_used  = g_lft_used | (used[k] & lft_mask[k]);
			g_lft_valid = g_lft_valid | (valid[k] & lft_mask[k]);
			g_rgt_len   = g_rgt_len | (len[k] & {AW{rgt_mask[k]}});
			g_rgt_used  = g_rgt_used | (used[k] & rgt_mask[k]);
			g_rgt_valid = g_rgt_valid | (valid[k] & rgt_mask[k]);
		end
	end

endmodule
